### rtl/core/mwc_pkg.sv
// Shared constants and control types for the multiply-with-carry random generator.
// Used by mwc_ctrl, mwc_dpath and mwc_random_generator_unit; depends on nothing else.
package mwc_pkg;

    localparam int WORD_W    = 32;
    localparam int HALF_W    = 16;
    localparam int MOD_W     = 30;
    localparam int BASE_W    = 31;
    localparam int MODE_W    = 2;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Request kinds carried in tuser.
    localparam logic [MODE_W-1:0] MODE_RESEED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAW    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANGED = 2'd2;

    // Configuration register indexes.
    localparam logic REG_RANGE_MODULUS = 1'b0;
    localparam logic REG_RANGE_BASE    = 1'b1;

    localparam logic [HALF_W-1:0] MUL_FIRST  = 16'd36969;
    localparam logic [HALF_W-1:0] MUL_SECOND = 16'd18000;

    localparam logic [WORD_W-1:0] SEED_ONE_FALLBACK = 32'h0BAD_B002;
    localparam logic [WORD_W-1:0] ZERO_SEED_SECOND  = 32'hDEAD_BEEF;
    localparam logic [WORD_W-1:0] ZERO_SEED_FIRST   = 32'hCAFE_BABE;

    localparam logic [MOD_W-1:0]  MODULUS_RESET = 30'd32768;
    localparam logic [BASE_W-1:0] BASE_RESET    = 31'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_seed;
        logic step;
        logic form_raw;
        logic div_init;
        logic div_step;
        logic fix;
        logic take_abs;
        logic load_out;
        logic sel_raw;
    } mwc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_zero;
    } mwc_sts_t;

endpackage

### rtl/core/mwc_random_generator_unit.sv
// Top level of the multiply-with-carry random generator: stream ports, configuration
// port and assertions. Depends on mwc_pkg, mwc_ctrl and mwc_dpath.

// The block holds two 32-bit seed words and serves one request word at a time.
// The request kind in tuser selects a reseed (the seed in tdata loads both words and
// no result word is sent), a raw draw, or a ranged draw; the fourth kind is dropped.
// A reseed leaves the block ready for the next request. After acceptance a raw draw
// updates the words, forms the 32-bit draw and loads it into the output register. A
// ranged draw adds a step to set up a signed remainder by range_modulus, done by a
// radix-2 restoring unit that retires one dividend bit per cycle, then a step to apply
// the sign and add range_base and one for the absolute value before the output register
// loads; with a modulus of zero the remainder is skipped. The next request is taken in
// the cycle after the output register loads, so a draw keeps the input closed until
// then. The result sits in an output register, so a new request is taken while the
// previous word waits for m_axis_tready; the block only stalls when a second result is
// ready before the first has been taken. Write the configuration registers only while
// the block is idle.
module mwc_random_generator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: index 0 is range_modulus (30 bits), index 1 is range_base (31 bits).
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] value
);

    mwc_pkg::mwc_cmd_t cmd;
    mwc_pkg::mwc_sts_t sts;

    mwc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_mode   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mwc_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seed      (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .result    (m_axis_tdata)
    );

    // A reseed word never makes the block busy.
    a_reseed_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == mwc_pkg::MODE_RESEED
        |=> s_axis_tready)
        else $error("block went busy after a reseed word");

    // A draw request keeps the input closed while it is being worked on.
    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tuser == mwc_pkg::MODE_RAW || s_axis_tuser == mwc_pkg::MODE_RANGED)
        |=> !s_axis_tready)
        else $error("input still open after accepting a draw word");

    // With a nonzero modulus the ranged draw is never negative.
    a_ranged_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && !cmd.sel_raw && !sts.mod_zero |=> !m_axis_tdata[31])
        else $error("ranged draw came out negative");

endmodule

### rtl/core/mwc_ctrl.sv
// Sequencing state machine for the multiply-with-carry random generator.
// Depends on mwc_pkg; drives the command struct consumed by mwc_dpath.
module mwc_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [mwc_pkg::MODE_W-1:0] in_mode,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  mwc_pkg::mwc_sts_t         sts,
    output mwc_pkg::mwc_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_RAW,
        ST_INIT,
        ST_DIV,
        ST_FIX,
        ST_ABS,
        ST_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic                      ranged_reg, ranged_next;
    logic [mwc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        ranged_next = ranged_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.sel_raw = !ranged_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode == mwc_pkg::MODE_RESEED)
                    begin
                        cmd.load_seed = 1'b1;
                    end
                    else if (in_mode inside {mwc_pkg::MODE_RAW, mwc_pkg::MODE_RANGED})
                    begin
                        ranged_next = (in_mode == mwc_pkg::MODE_RANGED);
                        state_next  = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = ST_RAW;
            end
            ST_RAW:
            begin
                cmd.form_raw = 1'b1;
                if (!ranged_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (sts.mod_zero)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == mwc_pkg::CNT_W'(mwc_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.take_abs = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.load_out | (out_valid_reg & !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ranged_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ranged_reg    <= ranged_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/core/mwc_dpath.sv
// Datapath of the multiply-with-carry random generator: seed words, configuration
// registers, radix-2 remainder unit and output register. Depends on mwc_pkg.
module mwc_dpath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [mwc_pkg::BASE_W-1:0]   cfg_data,
    input  logic [mwc_pkg::WORD_W-1:0]   seed,
    input  mwc_pkg::mwc_cmd_t            cmd,
    output mwc_pkg::mwc_sts_t            sts,
    output logic [mwc_pkg::WORD_W-1:0]   result
);

    localparam int W  = mwc_pkg::WORD_W;
    localparam int HW = mwc_pkg::HALF_W;
    localparam int MW = mwc_pkg::MOD_W;
    localparam int BW = mwc_pkg::BASE_W;

    logic [W-1:0]  first_reg, second_reg;
    logic [W-1:0]  first_next, second_next;
    logic [MW-1:0] modulus_reg;
    logic [BW-1:0] base_reg;
    logic [W-1:0]  raw_reg;
    logic [W-1:0]  mag_reg;
    logic [MW-1:0] rem_reg;
    logic [W-1:0]  res_reg;
    logic [W-1:0]  out_reg;

    logic [W-1:0]  f_fix, s_fix, a_word, b_word;
    logic [W-1:0]  seed_half;
    logic [MW:0]   rem_shift;
    logic [MW-1:0] rem_next;
    logic [W-1:0]  rem_signed;
    logic [W-1:0]  mod_val;

    // Reseed words and the crossed multiply-with-carry update.
    always_comb
    begin
        seed_half = seed >> 1;
        f_fix     = (first_reg == '0) ? W'(1) : first_reg;
        s_fix     = (second_reg == '0) ? W'(1) : second_reg;
        a_word    = W'({16'd0, mwc_pkg::MUL_FIRST} * {16'd0, f_fix[HW-1:0]})
                    + {16'd0, s_fix[W-1:HW]};
        b_word    = W'({16'd0, mwc_pkg::MUL_SECOND} * {16'd0, s_fix[HW-1:0]})
                    + {16'd0, f_fix[W-1:HW]};
        first_next  = first_reg;
        second_next = second_reg;
        if (cmd.load_seed)
        begin
            if (seed != '0)
            begin
                second_next = seed;
                first_next  = (seed_half == '0) ? mwc_pkg::SEED_ONE_FALLBACK : seed_half;
            end
            else
            begin
                second_next = mwc_pkg::ZERO_SEED_SECOND;
                first_next  = mwc_pkg::ZERO_SEED_FIRST;
            end
        end
        else if (cmd.step)
        begin
            first_next  = a_word;
            second_next = b_word;
        end
    end

    // One restoring step: remainder stays below the modulus, so it fits MW bits.
    always_comb
    begin
        rem_shift = {rem_reg, mag_reg[W-1]};
        if (rem_shift >= {1'b0, modulus_reg})
        begin
            rem_next = MW'(rem_shift - {1'b0, modulus_reg});
        end
        else
        begin
            rem_next = rem_shift[MW-1:0];
        end
        rem_signed = raw_reg[W-1] ? (W'(0) - {2'b00, rem_reg}) : {2'b00, rem_reg};
        mod_val    = (modulus_reg == '0) ? raw_reg : rem_signed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg   <= W'(1);
            second_reg  <= W'(1);
            modulus_reg <= mwc_pkg::MODULUS_RESET;
            base_reg    <= mwc_pkg::BASE_RESET;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            if (cfg_wr_en)
            begin
                if (cfg_index == mwc_pkg::REG_RANGE_MODULUS)
                begin
                    modulus_reg <= cfg_data[MW-1:0];
                end
                else
                begin
                    base_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.form_raw)
        begin
            raw_reg <= (first_reg << HW) + second_reg;
        end
        if (cmd.div_init)
        begin
            mag_reg <= raw_reg[W-1] ? (W'(0) - raw_reg) : raw_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            mag_reg <= mag_reg << 1;
            rem_reg <= rem_next;
        end
        if (cmd.fix)
        begin
            res_reg <= mod_val + {base_reg[BW-1], base_reg};
        end
        else if (cmd.take_abs)
        begin
            res_reg <= res_reg[W-1] ? (W'(0) - res_reg) : res_reg;
        end
        if (cmd.load_out)
        begin
            out_reg <= cmd.sel_raw ? raw_reg : res_reg;
        end
    end

    assign sts.mod_zero = (modulus_reg == '0);
    assign result       = out_reg;

endmodule

### tb/sv/mwc_random_generator_unit_tb.sv
// Self-checking testbench for mwc_random_generator_unit: directed and random request words,
// configuration sweeps and output back-pressure, checked against a built-in predictor.
// Depends on mwc_pkg and the RTL of mwc_random_generator_unit only.
module mwc_random_generator_unit_tb;

    // The fourth request kind has no meaning; the block drops it without a result word.
    localparam logic [mwc_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [mwc_pkg::MOD_W-1:0]  MODULUS_MAX = 30'h3FFF_FFFF;
    localparam logic [mwc_pkg::BASE_W-1:0] BASE_MIN    = 31'h4000_0000;  // -2^30
    localparam logic [mwc_pkg::BASE_W-1:0] BASE_MAX    = 31'h3FFF_FFFF;  // 2^30 - 1

    // Pauses before register writes and at the end of the run wait for every predicted
    // result word and then for SETTLE_CYCLES more, longer than a ranged draw takes.
    localparam int SETTLE_CYCLES = 64;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [30:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] seed_value
    logic [1:0]  s_axis_tuser;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] value

    // Predictor state: the two seed words and the two range registers as the block
    // should hold them.
    logic [mwc_pkg::WORD_W-1:0] gen_first;
    logic [mwc_pkg::WORD_W-1:0] gen_second;
    logic [mwc_pkg::MOD_W-1:0]  gen_modulus;
    logic [mwc_pkg::BASE_W-1:0] gen_base;

    // Draws predicted for accepted request words, oldest first.
    logic [mwc_pkg::WORD_W-1:0] pending_draws[$];

    int mismatch_count;

    // Knobs that the tests turn: random gaps on the request side, random stalls on the
    // result side, and a long hold-off of the result side counted by the sink process.
    bit src_idle_en;
    bit sink_idle_en;
    int hold_off_cycles;

    mwc_random_generator_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // One multiply-with-carry step with the crossed update: the high half of each word
    // feeds the other word. Zero words are forced to one before the step.
    function automatic logic [mwc_pkg::WORD_W-1:0] advance_raw();
        logic [mwc_pkg::WORD_W-1:0] next_first;
        logic [mwc_pkg::WORD_W-1:0] next_second;
        if (gen_second == '0)
            gen_second = 32'd1;
        if (gen_first == '0)
            gen_first = 32'd1;
        next_first  = 32'(mwc_pkg::MUL_FIRST) * {16'd0, gen_first[15:0]}
                      + {16'd0, gen_second[31:16]};
        next_second = 32'(mwc_pkg::MUL_SECOND) * {16'd0, gen_second[15:0]}
                      + {16'd0, gen_first[31:16]};
        gen_first   = next_first;
        gen_second  = next_second;
        return (next_first << 16) + next_second;
    endfunction

    // Ranged draw: signed remainder truncating toward zero (skipped for a zero modulus),
    // plus the sign-extended base, then an absolute value that wraps at -2^31.
    function automatic logic [mwc_pkg::WORD_W-1:0] advance_ranged();
        logic [mwc_pkg::WORD_W-1:0] raw;
        logic [mwc_pkg::WORD_W-1:0] magnitude;
        logic [mwc_pkg::WORD_W-1:0] remainder;
        logic [mwc_pkg::WORD_W-1:0] total;
        raw = advance_raw();
        remainder = raw;
        if (gen_modulus != '0)
        begin
            magnitude = raw[31] ? -raw : raw;
            remainder = magnitude % {2'b00, gen_modulus};
            if (raw[31])
                remainder = -remainder;
        end
        total = remainder + {gen_base[30], gen_base};
        if (total[31])
            total = -total;
        return total;
    endfunction

    // Applies one accepted request word to the predictor and queues its draw, if any.
    task automatic predict_request(input logic [mwc_pkg::MODE_W-1:0] kind,
                                   input logic [mwc_pkg::WORD_W-1:0] seed);
        case (kind)
            mwc_pkg::MODE_RESEED:
            begin
                if (seed != '0)
                begin
                    gen_second = seed;
                    gen_first  = seed >> 1;
                    if (gen_first == '0)
                        gen_first = mwc_pkg::SEED_ONE_FALLBACK;
                end
                else
                begin
                    gen_second = mwc_pkg::ZERO_SEED_SECOND;
                    gen_first  = mwc_pkg::ZERO_SEED_FIRST;
                end
            end
            mwc_pkg::MODE_RAW:    pending_draws.push_back(advance_raw());
            mwc_pkg::MODE_RANGED: pending_draws.push_back(advance_ranged());
            default:              ;
        endcase
    endtask

    // Offers one request word and waits for the handshake. Called at a falling edge with
    // tvalid low; returns at a falling edge with tvalid low again, so a following call
    // with no gap raises it in the same step and the stream stays back to back.
    task automatic send_request(input logic [mwc_pkg::MODE_W-1:0] kind,
                                input logic [mwc_pkg::WORD_W-1:0] seed);
        int unsigned gap;
        gap = src_idle_en ? pick_gap() : 0;
        repeat (gap) @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = seed;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_request(kind, seed);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Waits until every predicted draw has come out and the block has had time to finish
    // any word that gives no result.
    task automatic wait_quiet();
        while (pending_draws.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write; called at a falling edge while the block is idle.
    task automatic write_reg(input logic idx, input logic [30:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (idx == mwc_pkg::REG_RANGE_MODULUS)
            gen_modulus = data[mwc_pkg::MOD_W-1:0];
        else
            gen_base = data[mwc_pkg::BASE_W-1:0];
    endtask

    // Sets both range registers. The unused top bit of a modulus write carries noise,
    // which the register must drop.
    task automatic set_range(input logic [mwc_pkg::MOD_W-1:0] modulus,
                             input logic [mwc_pkg::BASE_W-1:0] base);
        wait_quiet();
        write_reg(mwc_pkg::REG_RANGE_MODULUS, {1'($urandom_range(0, 1)), modulus});
        write_reg(mwc_pkg::REG_RANGE_BASE, base);
    endtask

    function automatic logic [mwc_pkg::MODE_W-1:0] pick_mode();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return mwc_pkg::MODE_RESEED;
        else if (roll < 50)
            return mwc_pkg::MODE_RAW;
        else if (roll < 95)
            return mwc_pkg::MODE_RANGED;
        else
            return MODE_UNUSED;
    endfunction

    // Seeds: mostly full 32-bit values, sometimes the corner values that pick the
    // fallback words or lead to a zero word after one step.
    function automatic logic [mwc_pkg::WORD_W-1:0] pick_seed();
        case ($urandom_range(0, 19))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'h0001_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [mwc_pkg::MOD_W-1:0] pick_modulus();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return MODULUS_MAX;
            2:       return 30'd1;
            3, 4:    return 30'($urandom_range(2, 20));
            default: return 30'($urandom());
        endcase
    endfunction

    function automatic logic [mwc_pkg::BASE_W-1:0] pick_base();
        case ($urandom_range(0, 7))
            0:       return BASE_MIN;
            1:       return BASE_MAX;
            2:       return '0;
            default: return 31'($urandom());
        endcase
    endfunction

    task automatic send_random_words(input int count);
        repeat (count) send_request(pick_mode(), pick_seed());
    endtask

    // Result side: drives tready at every falling edge. A requested hold-off takes
    // precedence, then any random stall that is under way.
    initial
    begin : result_sink
        int unsigned stall_left;
        m_axis_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                m_axis_tready = 1'b0;
                hold_off_cycles = hold_off_cycles - 1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (sink_idle_en && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Every accepted result word is compared with the oldest predicted draw.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_draws.size() == 0)
            begin
                $error("unexpected result word: value = %h", m_axis_tdata);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                if (m_axis_tdata !== pending_draws[0])
                begin
                    $error("value mismatch: expected %h, actual %h",
                           pending_draws[0], m_axis_tdata);
                    mismatch_count = mismatch_count + 1;
                end
                void'(pending_draws.pop_front());
            end
        end
    end

    // The default range registers and seed words as they come out of reset.
    task automatic test_reset_state();
        send_request(mwc_pkg::MODE_RAW, 32'd0);
        send_request(mwc_pkg::MODE_RANGED, 32'd0);
        send_request(mwc_pkg::MODE_RAW, 32'hFFFF_FFFF);
    endtask

    // Each request kind and each seed corner: the zero seed, the seed whose half is zero,
    // a seed that leaves a zero word after one step, the extremes of the seed field, and
    // the dropped kind carrying data.
    task automatic test_seed_corners();
        send_request(mwc_pkg::MODE_RESEED, 32'd0);
        send_request(mwc_pkg::MODE_RAW, 32'd0);
        send_request(mwc_pkg::MODE_RANGED, 32'd0);
        send_request(mwc_pkg::MODE_RESEED, 32'd1);
        send_request(mwc_pkg::MODE_RAW, 32'd0);
        send_request(mwc_pkg::MODE_RESEED, 32'h0001_0000);
        send_request(mwc_pkg::MODE_RAW, 32'd0);
        send_request(mwc_pkg::MODE_RAW, 32'd0);
        send_request(mwc_pkg::MODE_RANGED, 32'd0);
        send_request(mwc_pkg::MODE_RESEED, 32'hFFFF_FFFF);
        send_request(mwc_pkg::MODE_RANGED, 32'hFFFF_FFFF);
        send_request(mwc_pkg::MODE_RESEED, 32'h8000_0000);
        send_request(MODE_UNUSED, 32'h1234_5678);
        send_request(mwc_pkg::MODE_RAW, 32'hFFFF_FFFF);
        send_request(mwc_pkg::MODE_RESEED, 32'd2);
        send_request(MODE_UNUSED, 32'hFFFF_FFFF);
        send_request(mwc_pkg::MODE_RANGED, 32'd0);
        send_request(mwc_pkg::MODE_RAW, 32'd0);
    endtask

    // Ranged draws under the extreme register settings, including a zero modulus, where
    // the remainder step is bypassed and the absolute value may wrap.
    task automatic test_range_extremes();
        logic [mwc_pkg::MOD_W-1:0]  moduli[8];
        logic [mwc_pkg::BASE_W-1:0] bases[8];
        moduli = '{30'd1, MODULUS_MAX, 30'd0, 30'd0, mwc_pkg::MODULUS_RESET, 30'd3,
                   MODULUS_MAX, 30'd0};
        bases  = '{BASE_MIN, BASE_MAX, 31'd0, BASE_MIN, 31'd0, BASE_MAX, BASE_MIN, BASE_MAX};
        for (int i = 0; i < 8; i++)
        begin
            set_range(moduli[i], bases[i]);
            send_random_words(25);
        end
    endtask

    // Long random traffic in blocks, each with a fresh register setting. Idling on
    // either side is switched per block, and one block runs with none at all.
    task automatic test_random_traffic();
        for (int blk = 0; blk < 6; blk++)
        begin
            set_range(pick_modulus(), pick_base());
            src_idle_en  = (blk != 2) && ($urandom_range(0, 3) != 0);
            sink_idle_en = (blk != 2) && ($urandom_range(0, 3) != 0);
            send_random_words(100);
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // The result side holds off for a long stretch while request words keep coming, so
    // the output register fills and the block must stop taking requests.
    task automatic test_output_backpressure();
        set_range(30'd1000, BASE_MIN);
        src_idle_en = 1'b0;
        hold_off_cycles = 400;
        repeat (30) send_request(mwc_pkg::MODE_RAW, 32'd0);
        hold_off_cycles = 300;
        repeat (30) send_request(($urandom_range(0, 1) == 0) ? mwc_pkg::MODE_RAW
                                                             : mwc_pkg::MODE_RANGED, 32'd0);
        src_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = mwc_pkg::REG_RANGE_MODULUS;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = mwc_pkg::MODE_RESEED;
        gen_first      = 32'd1;
        gen_second     = 32'd1;
        gen_modulus    = mwc_pkg::MODULUS_RESET;
        gen_base       = mwc_pkg::BASE_RESET;
        mismatch_count = 0;
        src_idle_en    = 1'b1;
        sink_idle_en   = 1'b1;
        hold_off_cycles = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_seed_corners();
        test_range_extremes();
        test_random_traffic();
        test_output_backpressure();

        wait_quiet();
        if (pending_draws.size() != 0)
            mismatch_count = mismatch_count + 1;
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every draw ranged and every
    // gap and stall at its longest.
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
